@@ design/plb_pkg.sv @@
// Shared types, constants and defaults for the percentile level bisection block.
package plb_pkg;

  localparam int unsigned DEPTH_DEFAULT         = 4096;
  localparam int unsigned FRACTION_BITS_DEFAULT = 16;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned BELOW_W    = 13;
  localparam int unsigned FRACTION_W = 17;
  localparam int unsigned ROUNDS_W   = 6;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ONE_W      = 16;

  localparam logic [CFG_IDX_W-1:0]  REG_TARGET_FRACTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_ROUND_COUNT     = 1'd1;
  localparam logic [FRACTION_W-1:0] FRACTION_RESET      = 17'd32768;
  localparam logic [ROUNDS_W-1:0]   ROUNDS_RESET        = 6'd8;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_MID,
    ST_SWEEP,
    ST_DECIDE,
    ST_DONE
  } plb_state_t;

endpackage

@@ design/plb_if.sv @@
// Request channel interfaces for samples in and levels out.
interface plb_in_if
  import plb_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface plb_out_if
  import plb_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;
  logic [BELOW_W-1:0]        below_count;

  modport source (output valid, level, below_count, input ready);
  modport sink   (input valid, level, below_count, output ready);
endinterface

@@ design/percentile_level_bisection.sv @@
// Top level: sample loading, min/max tracking and threshold bisection over stored samples.
//
//   channel   dir  payload                    handshake
//   samples   in   sample[15:0] s, last       valid/ready
//   results   out  level[31:0] s, below[12:0] valid/ready
//   cfg       in   cfg_index, cfg_data[16:0]  cfg_write, no wait
//
// Samples load at one per cycle. After the last sample of a set, each of R rounds
// sweeps the N stored samples through the single read port of the store. A set of zero
// rounds goes straight from start to done. No samples are taken during bisection.
// A finished level waits in the output register while the next set loads.
// Reset is synchronous; the store holds no reset value.
module percentile_level_bisection
  import plb_pkg::*;
#(
  parameter int unsigned DEPTH         = DEPTH_DEFAULT,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  plb_in_if.sink                samples,
  plb_out_if.source             results
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = SAMPLE_W + 1 + FRACTION_BITS;
  localparam int unsigned PW = CW + FRACTION_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic signed [63:0] LEVEL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] LEVEL_MIN = -64'sh0000_0000_8000_0000;

  plb_state_t state, state_next;

  logic [FRACTION_W-1:0]      target_fraction;
  logic [ROUNDS_W-1:0]        round_count;
  logic [CW-1:0]              loaded;
  logic signed [SAMPLE_W-1:0] smallest;
  logic signed [SAMPLE_W-1:0] largest;
  logic signed [LW-1:0]       lower_bound;
  logic signed [LW-1:0]       upper_bound;
  logic signed [LW-1:0]       mid;
  logic [PW-1:0]              quota;
  logic [CW-1:0]              running_below;
  logic [ROUNDS_W-1:0]        round_index;
  logic [CW-1:0]              rd_addr;
  logic                       rd_valid;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       out_valid;
  logic signed [LEVEL_W-1:0]  out_level;
  logic [BELOW_W-1:0]         out_below;

  logic                       in_ready;
  logic                       accept;
  logic                       store_wr;
  logic                       issue;
  logic                       rd_en;
  logic                       out_free;
  logic                       round_last;
  logic                       go_up;
  logic signed [LW:0]         bound_sum;
  logic signed [LW-1:0]       scaled;
  logic signed [63:0]         mid_wide;
  logic signed [LEVEL_W-1:0]  mid_sat;

  plb_sample_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (loaded[AW-1:0]),
    .wr_data (samples.sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  assign accept     = samples.valid && in_ready;
  assign store_wr   = accept && (loaded != FULL);
  assign issue      = (rd_addr != loaded);
  assign out_free   = !out_valid || results.ready;
  assign round_last = ((round_index + ROUNDS_W'(1)) == round_count);
  assign go_up      = (PW'({running_below, {ONE_W{1'b0}}}) > quota);
  assign bound_sum  = (LW + 1)'(lower_bound) + (LW + 1)'(upper_bound);
  assign scaled     = LW'(rd_data) <<< FRACTION_BITS;
  assign mid_wide   = 64'(mid);

  always_comb begin
    if (mid_wide > LEVEL_MAX) begin
      mid_sat = LEVEL_MAX[LEVEL_W-1:0];
    end else if (mid_wide < LEVEL_MIN) begin
      mid_sat = LEVEL_MIN[LEVEL_W-1:0];
    end else begin
      mid_sat = mid_wide[LEVEL_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && samples.last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = (round_count == '0) ? ST_DONE : ST_MID;
      end
      ST_MID: begin
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!issue && !rd_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = round_last ? ST_DONE : ST_MID;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    case (state)
      ST_LOAD:  in_ready = 1'b1;
      ST_SWEEP: rd_en    = issue;
      default: begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_fraction <= FRACTION_RESET;
      round_count     <= ROUNDS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_FRACTION: target_fraction <= cfg_data[FRACTION_W-1:0];
        REG_ROUND_COUNT:     round_count     <= cfg_data[ROUNDS_W-1:0];
        default: begin
          target_fraction <= target_fraction;
          round_count     <= round_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      smallest <= '0;
      largest  <= '0;
    end else if (store_wr) begin
      loaded <= loaded + CW'(1);
      if (loaded == '0) begin
        smallest <= samples.sample;
        largest  <= samples.sample;
      end else begin
        if (samples.sample < smallest) begin
          smallest <= samples.sample;
        end
        if (samples.sample > largest) begin
          largest <= samples.sample;
        end
      end
    end else if (state == ST_DONE && out_free) begin
      loaded   <= '0;
      smallest <= '0;
      largest  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr       <= '0;
      rd_valid      <= 1'b0;
      round_index   <= '0;
      running_below <= '0;
      lower_bound   <= '0;
      upper_bound   <= '0;
      mid           <= '0;
      quota         <= '0;
    end else begin
      rd_valid <= rd_en;
      case (state)
        ST_START: begin
          lower_bound   <= LW'(smallest) <<< FRACTION_BITS;
          upper_bound   <= LW'(largest) <<< FRACTION_BITS;
          quota         <= PW'(target_fraction) * PW'(loaded);
          round_index   <= '0;
          running_below <= '0;
          mid           <= '0;
        end
        ST_MID: begin
          mid           <= bound_sum[LW:1];
          rd_addr       <= '0;
          running_below <= '0;
        end
        ST_SWEEP: begin
          if (issue) begin
            rd_addr <= rd_addr + CW'(1);
          end
          if (rd_valid && (scaled < mid)) begin
            running_below <= running_below + CW'(1);
          end
        end
        ST_DECIDE: begin
          if (go_up) begin
            upper_bound <= mid;
          end else begin
            lower_bound <= mid;
          end
          round_index <= round_index + ROUNDS_W'(1);
        end
        default: begin
          rd_addr <= rd_addr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_level <= mid_sat;
      out_below <= BELOW_W'(running_below);
    end
  end

  assign samples.ready       = in_ready;
  assign results.valid       = out_valid;
  assign results.level       = out_level;
  assign results.below_count = out_below;

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done state");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> rd_addr <= loaded)
    else $error("sweep address ran past the loaded samples");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |-> running_below <= loaded)
    else $error("below count exceeds loaded samples");

  a_no_load_in_bisection: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP || state == ST_MID) |=> $stable(loaded))
    else $error("sample store changed during a round");

endmodule

@@ design/plb_sample_store.sv @@
// Sample memory: one write port, one registered read port.
module plb_sample_store
  import plb_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
